// ----- src/innovation_residual_fault_detector_defines.svh -----
// assertion macros shared by the fault detector modules
`ifndef INNOVATION_RESIDUAL_FAULT_DETECTOR_DEFINES_SVH
`define INNOVATION_RESIDUAL_FAULT_DETECTOR_DEFINES_SVH

// consequent checked in the same cycle
`define IRFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define IRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/irfd_pkg.sv -----
// package with widths, constants and shared types of the fault detector
package irfd_pkg;

  localparam int unsigned INNOV_W    = 32;
  localparam int unsigned VAR_W      = 32;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned SQ_W       = 2 * INNOV_W - 1;
  localparam int unsigned DIV_STEPS  = SQ_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [THR_W-1:0]      THR_RESET      = 16'd15;
  localparam logic [CFG_ADDR_W-1:0] REG_FAULT_THR  = 2'd0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/irfd_if.sv -----
// valid/ready channel interfaces for input terms and residual results
interface irfd_in_if;
  import irfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [INNOV_W-1:0] innovation;
  logic [VAR_W-1:0]   variance;
  logic               last_term;

  modport source (output valid, innovation, variance, last_term, input ready);
  modport sink (input valid, innovation, variance, last_term, output ready);
endinterface

interface irfd_out_if;
  import irfd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] power_sum;
  logic             fault_detected;

  modport source (output valid, power_sum, fault_detected, input ready);
  modport sink (input valid, power_sum, fault_detected, output ready);
endinterface

// ----- src/innovation_residual_fault_detector.sv -----
// top level: normalized innovation squared accumulator with fault flag
// a term with zero variance skips the divider and adds zero to the sum
// any other term is divided by its variance in the 63-step divider loop
// one term is in flight at a time; the result waits in an output register
// reset clears the accumulator, the sequencer and the output valid flag
// reset loads the fault threshold with 15
`include "innovation_residual_fault_detector_defines.svh"

module innovation_residual_fault_detector #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  irfd_in_if.sink                         in_i,
  irfd_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [irfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [irfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [irfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import irfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [INNOV_W-1:0] innov_q, innov_d;
  logic [VAR_W-1:0]   var_q, var_d;
  logic               last_q, last_d;
  logic [ACC_W-1:0]   term_q, term_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [ACC_W-1:0]   res_q, res_d;
  logic               fault_q, fault_d;

  logic [THR_W-1:0]   thr;
  logic [INNOV_W-1:0] mag;
  logic [2*INNOV_W-1:0] sq;
  logic               div_start;
  div_stat_t          div_stat;
  logic [ACC_W-1:0]   div_quo;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   sum_sat;
  logic [ACC_W-1:0]   limit;
  logic               accept;
  logic               emit;
  logic               room;

  irfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  assign mag       = innov_q[INNOV_W-1] ? (~innov_q + 1'b1) : innov_q;
  assign sq        = (2*INNOV_W)'(mag) * (2*INNOV_W)'(mag);
  assign div_start = (state_q == ST_SQ);

  irfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sq[SQ_W-1:0]),
    .divisor_i  (var_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign sum     = {1'b0, acc_q} + {1'b0, term_q};
  assign sum_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  assign limit   = ACC_W'(thr) << FRAC_BITS;
  assign room    = !out_valid_q || out_o.ready;
  assign emit    = (state_q == ST_ACC) && last_q && room;

  always_comb begin
    state_d     = state_q;
    innov_d     = innov_q;
    var_d       = var_q;
    last_d      = last_q;
    term_d      = term_q;
    acc_d       = acc_q;
    res_d       = res_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          innov_d = in_i.innovation;
          var_d   = in_i.variance;
          last_d  = in_i.last_term;
          if (in_i.variance == '0) begin
            term_d  = '0;
            state_d = ST_ACC;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          term_d  = div_quo;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last_q) begin
          acc_d   = sum_sat;
          state_d = ST_IDLE;
        end else if (room) begin
          res_d       = sum_sat;
          fault_d     = (sum_sat > limit);
          out_valid_d = 1'b1;
          acc_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    innov_q <= innov_d;
    var_q   <= var_d;
    last_q  <= last_d;
    term_q  <= term_d;
    res_q   <= res_d;
    fault_q <= fault_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.power_sum      = res_q;
  assign out_o.fault_detected = fault_q;

  `IRFD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_i.ready, "ready after accept")
  `IRFD_ASSERT_NOW(a_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV, "stray done")
  `IRFD_ASSERT_NEXT(a_clear_after_emit, clk_i, rst_ni, emit, acc_q == '0, "accumulator kept")
  `IRFD_ASSERT_NOW(a_div_busy_in_div, clk_i, rst_ni, div_stat.busy, state_q == ST_DIV, "stray busy")

endmodule

// ----- src/irfd_cfg.sv -----
// apb register block holding the fault threshold
module irfd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [irfd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [irfd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [irfd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [irfd_pkg::THR_W-1:0]         thr_o
);
  import irfd_pkg::*;

  logic [THR_W-1:0]      thr_q, thr_d;
  logic [CFG_ADDR_W-1:0] word_idx;
  logic                  wr_en;

  assign pready   = 1'b1;
  assign word_idx = paddr >> 2;
  assign wr_en    = psel && penable && pwrite && pready;

  always_comb begin
    thr_d = thr_q;
    if (wr_en && (word_idx == REG_FAULT_THR)) begin
      thr_d = pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (word_idx == REG_FAULT_THR) begin
      prdata = {{(CFG_DATA_W-THR_W){1'b0}}, thr_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

// ----- src/irfd_div.sv -----
// iterative restoring divider, one quotient bit per cycle, saturating result
`include "innovation_residual_fault_detector_defines.svh"

module irfd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [irfd_pkg::SQ_W-1:0]    dividend_i,
  input  logic [irfd_pkg::VAR_W-1:0]   divisor_i,
  output irfd_pkg::div_stat_t          stat_o,
  output logic [irfd_pkg::ACC_W-1:0]   quotient_o
);
  import irfd_pkg::*;

  logic [VAR_W-1:0]     rem_q, rem_d;
  logic [SQ_W-1:0]      dq_q, dq_d;
  logic [VAR_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [VAR_W:0]       shifted;
  logic [VAR_W+1:0]     diff;
  logic                 take;

  assign shifted = {rem_q, dq_q[SQ_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign take    = !diff[VAR_W+1];

  always_comb begin
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[VAR_W-1:0] : shifted[VAR_W-1:0];
      dq_d  = {dq_q[SQ_W-2:0], take};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = (|dq_q[SQ_W-1:ACC_W]) ? {ACC_W{1'b1}} : dq_q[ACC_W-1:0];

  `IRFD_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i, busy_q, "divider not busy after start")
  `IRFD_ASSERT_NOW(a_start_idle, clk_i, rst_ni, start_i, !busy_q, "divider started while busy")
  `IRFD_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q && !busy_q, "done not a pulse")

endmodule
